>>> rtl/core/mapp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapp_pkg
// Shared constants, register codes and the command, status and configuration
// structures of the pooling engine.
// ----------------------------------------------------------------------------
package mapp_pkg;

   localparam int MAX_DIM     = 64;
   localparam int MAX_WINDOW  = 8;
   localparam int SAMPLE_BITS = 16;

   localparam int DIM_BITS    = $clog2(MAX_DIM);
   localparam int ADDR_BITS   = 2 * DIM_BITS;
   localparam int SIZE_BITS   = 7;
   localparam int WIN_BITS    = 4;
   localparam int PROD_BITS   = DIM_BITS + SIZE_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int COUNT_BITS  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int ACC_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
   localparam int DIV_STEPS   = ACC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 7;

   // Request codes.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Pooling modes.
   localparam logic MODE_MAX = 1'b0;
   localparam logic MODE_AVG = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRIDE       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_MODE    = 3'd4;

   typedef struct packed {
      logic [SIZE_BITS-1:0] image_height;
      logic [SIZE_BITS-1:0] image_width;
      logic [WIN_BITS-1:0]  window_size;
      logic [SIZE_BITS-1:0] stride;
      logic                 pool_mode;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic prod;
      logic setup;
      logic scan_issue;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic empty;
      logic avg_mode;
      logic scan_last;
      logic div_done;
   } status_type;

endpackage

>>> rtl/core/mapp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapp_ctrl
// Sequencer of the pooling engine: accepts requests, steps the datapath
// through window scan and divide, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mapp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mapp_pkg::status_type status,
   output mapp_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_type == mapp_pkg::REQ_QUERY) begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.err || status.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last sample is folded into the accumulator in this cycle.
            state_in = status.avg_mode ? ST_DIV_LOAD : ST_DONE;
         end
         ST_DIV_LOAD: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/mapp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapp_datapath
// Plane memory, window address generator, max/sum accumulator, serial
// divider and result register of the pooling engine.
// ----------------------------------------------------------------------------
module mapp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mapp_pkg::cfg_type                     cfg,
   input  mapp_pkg::cmd_type                     cmd,
   output mapp_pkg::status_type                  status,
   input  logic                                  req_type,
   input  logic [mapp_pkg::DIM_BITS-1:0]         req_row_index,
   input  logic [mapp_pkg::DIM_BITS-1:0]         req_col_index,
   input  logic signed [mapp_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic signed [mapp_pkg::SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic                                  rsp_index_error
);

   localparam int DB = mapp_pkg::DIM_BITS;
   localparam int SB = mapp_pkg::SAMPLE_BITS;
   localparam int AB = mapp_pkg::ACC_BITS;
   localparam int PB = mapp_pkg::PROD_BITS;
   localparam int UB = mapp_pkg::SUM_BITS;
   localparam int CB = mapp_pkg::COUNT_BITS;
   localparam int DEPTH = 1 << mapp_pkg::ADDR_BITS;

   logic signed [SB-1:0] plane_mem [DEPTH];

   logic [DB-1:0]        row_ff, col_ff;
   logic [PB-1:0]        hstart_ff, wstart_ff;
   logic [DB-1:0]        hlast_ff, wlast_ff, h_ff, w_ff;
   logic                 err_ff, empty_ff;
   logic signed [SB-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic signed [AB-1:0] acc_ff;
   logic [CB-1:0]        count_ff;
   logic [AB-1:0]        quo_ff;
   logic [CB-1:0]        rem_ff;
   logic                 neg_ff;
   logic [mapp_pkg::DIV_CNT_BITS-1:0] div_cnt_ff;
   logic signed [SB-1:0] value_ff;
   logic                 error_ff;

   logic                 mem_we;
   logic                 cfg_bad, win_big, row_out, col_out, err_c, empty_c;
   logic [UB-1:0]        hend_sum, wend_sum, hend, wend;
   logic signed [AB-1:0] rd_ext, acc_init;
   logic [AB-1:0]        acc_mag;
   logic [CB:0]          trial;
   logic                 trial_ge;
   logic [SB-1:0]        avg_value;

   // Sample writes land in the plane at the accepting edge.
   assign mem_we = cmd.capture && (req_type == mapp_pkg::REQ_WRITE) &&
                   ({1'b0, req_row_index} < cfg.image_height) &&
                   ({1'b0, req_col_index} < cfg.image_width);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[{req_row_index, req_col_index}] <= req_sample;
      end
      if (cmd.scan_issue) begin
         rd_data_ff <= plane_mem[{h_ff, w_ff}];
      end
   end

   assign cfg_bad = (cfg.image_height == '0) ||
                    (cfg.image_height > mapp_pkg::SIZE_BITS'(mapp_pkg::MAX_DIM)) ||
                    (cfg.image_width == '0) ||
                    (cfg.image_width > mapp_pkg::SIZE_BITS'(mapp_pkg::MAX_DIM)) ||
                    (cfg.window_size == '0) ||
                    (cfg.window_size > mapp_pkg::WIN_BITS'(mapp_pkg::MAX_WINDOW)) ||
                    (cfg.stride == '0);
   assign win_big = (mapp_pkg::SIZE_BITS'(cfg.window_size) > cfg.image_height) ||
                    (mapp_pkg::SIZE_BITS'(cfg.window_size) > cfg.image_width);

   assign hend_sum = UB'(hstart_ff) + UB'(cfg.window_size);
   assign wend_sum = UB'(wstart_ff) + UB'(cfg.window_size);

   // Inside the grid exactly when start + window < size + stride.
   assign row_out = hend_sum >= (UB'(cfg.image_height) + UB'(cfg.stride));
   assign col_out = wend_sum >= (UB'(cfg.image_width) + UB'(cfg.stride));
   assign err_c   = cfg_bad || win_big || row_out || col_out;
   assign empty_c = (hstart_ff >= PB'(cfg.image_height)) ||
                    (wstart_ff >= PB'(cfg.image_width));

   assign hend = (hend_sum > UB'(cfg.image_height)) ? UB'(cfg.image_height) : hend_sum;
   assign wend = (wend_sum > UB'(cfg.image_width)) ? UB'(cfg.image_width) : wend_sum;

   assign acc_init = (cfg.pool_mode == mapp_pkg::MODE_AVG) ? '0 :
                     $signed({{(AB-SB+1){1'b1}}, {(SB-1){1'b0}}});
   assign rd_ext   = $signed({{(AB-SB){rd_data_ff[SB-1]}}, rd_data_ff});
   assign acc_mag  = acc_ff[AB-1] ? (~$unsigned(acc_ff) + 1'b1) : $unsigned(acc_ff);

   assign trial    = {rem_ff, quo_ff[AB-1]};
   assign trial_ge = trial >= {1'b0, count_ff};
   assign avg_value = neg_ff ? (~quo_ff[SB-1:0] + 1'b1) : quo_ff[SB-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
      end
      if (cmd.prod) begin
         hstart_ff <= PB'(row_ff) * PB'(cfg.stride);
         wstart_ff <= PB'(col_ff) * PB'(cfg.stride);
      end
      if (cmd.setup) begin
         err_ff   <= err_c;
         empty_ff <= empty_c;
         hlast_ff <= DB'(hend - 1'b1);
         wlast_ff <= DB'(wend - 1'b1);
         h_ff     <= hstart_ff[DB-1:0];
         w_ff     <= wstart_ff[DB-1:0];
         acc_ff   <= acc_init;
         count_ff <= '0;
      end else begin
         if (cmd.scan_issue) begin
            if (w_ff == wlast_ff) begin
               w_ff <= wstart_ff[DB-1:0];
               h_ff <= h_ff + 1'b1;
            end else begin
               w_ff <= w_ff + 1'b1;
            end
         end
         if (rd_vld_ff) begin
            count_ff <= count_ff + 1'b1;
            if (cfg.pool_mode == mapp_pkg::MODE_AVG) begin
               acc_ff <= acc_ff + rd_ext;
            end else if (rd_ext > acc_ff) begin
               acc_ff <= rd_ext;
            end
         end
      end
      if (cmd.div_init) begin
         neg_ff     <= acc_ff[AB-1];
         quo_ff     <= acc_mag;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= trial_ge ? CB'(trial - {1'b0, count_ff}) : trial[CB-1:0];
         quo_ff     <= {quo_ff[AB-2:0], trial_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         error_ff <= err_ff;
         if (err_ff) begin
            value_ff <= '0;
         end else if ((cfg.pool_mode == mapp_pkg::MODE_AVG) && !empty_ff) begin
            value_ff <= $signed(avg_value);
         end else begin
            value_ff <= acc_ff[SB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_issue;
      end
   end

   assign status.err       = err_c;
   assign status.empty     = empty_c;
   assign status.avg_mode  = (cfg.pool_mode == mapp_pkg::MODE_AVG);
   assign status.scan_last = (h_ff == hlast_ff) && (w_ff == wlast_ff);
   assign status.div_done  = (div_cnt_ff == mapp_pkg::DIV_CNT_BITS'(mapp_pkg::DIV_STEPS - 1));

   assign rsp_pooled_value = value_ff;
   assign rsp_index_error  = error_ff;

endmodule

>>> rtl/core/max_avg_pooling_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_avg_pooling_engine
// Max and average pooling over one feature plane held in on-chip memory.
// ----------------------------------------------------------------------------
// A write request stores its sample in the 64 x 64 plane
// memory; writes outside the configured plane are dropped and give no
// response. A query passes through capture, the start product and address
// and range checking, then reads one sample of the clipped window per cycle
// (up to 64, one memory read port read per cycle), passes a drain state,
// and in average mode runs the bit-serial divide before the response
// register is loaded. Error and empty-window queries skip the scan.
// The plane memory is not cleared at reset, so every pixel a query covers
// must be written first. The user must write configuration registers only
// while the engine is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module max_avg_pooling_engine (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_type,
   input  logic [mapp_pkg::DIM_BITS-1:0]           req_row_index,
   input  logic [mapp_pkg::DIM_BITS-1:0]           req_col_index,
   input  logic signed [mapp_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [mapp_pkg::SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic                                    rsp_index_error,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mapp_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [mapp_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   mapp_pkg::cfg_type    cfg_ff, cfg_in;
   mapp_pkg::cmd_type    cmd;
   mapp_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mapp_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            mapp_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            mapp_pkg::CSR_WINDOW_SIZE:  cfg_in.window_size  = csr_data[mapp_pkg::WIN_BITS-1:0];
            mapp_pkg::CSR_STRIDE:       cfg_in.stride       = csr_data;
            mapp_pkg::CSR_POOL_MODE:    cfg_in.pool_mode    = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height <= mapp_pkg::SIZE_BITS'(8);
         cfg_ff.image_width  <= mapp_pkg::SIZE_BITS'(8);
         cfg_ff.window_size  <= mapp_pkg::WIN_BITS'(2);
         cfg_ff.stride       <= mapp_pkg::SIZE_BITS'(2);
         cfg_ff.pool_mode    <= mapp_pkg::MODE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mapp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mapp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_sample       (req_sample),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_index_error  (rsp_index_error)
   );

`ifndef ASSERT_OFF
   // An error response always carries a zero value.
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_pooled_value == '0)
      else $error("error response with nonzero pooled value");

   // A sample write transfer never blocks the next request.
   a_write_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == mapp_pkg::REQ_WRITE) |=> req_ready)
      else $error("engine busy after a write transfer");

   // A query transfer keeps the request side closed while it is worked on.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == mapp_pkg::REQ_QUERY) |=> !req_ready ##1 !req_ready)
      else $error("request accepted while a query is in progress");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the max / average pooling engine. A queue of
// sample writes and pooled-output queries feeds a valid/ready driver; a
// shadow plane and configuration predict every query response, and a monitor
// compares each response transfer with the oldest prediction. The run covers
// the default, extreme, empty-window and invalid configurations, then random
// planes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_PERIOD = 12;
   localparam int DRAIN_CYCLES = 100;
   localparam int RUN_LIMIT    = 1500000;
   localparam int RANDOM_PHASES = 18;

   typedef struct {
      logic                                    kind;
      logic [mapp_pkg::DIM_BITS-1:0]           row;
      logic [mapp_pkg::DIM_BITS-1:0]           col;
      logic signed [mapp_pkg::SAMPLE_BITS-1:0] sample;
   } pool_request_type;

   typedef struct {
      logic signed [mapp_pkg::SAMPLE_BITS-1:0] pooled_value;
      logic                                    index_error;
   } pool_result_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic                                    req_type = mapp_pkg::REQ_WRITE;
   logic [mapp_pkg::DIM_BITS-1:0]           req_row_index = '0;
   logic [mapp_pkg::DIM_BITS-1:0]           req_col_index = '0;
   logic signed [mapp_pkg::SAMPLE_BITS-1:0] req_sample = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [mapp_pkg::SAMPLE_BITS-1:0] rsp_pooled_value;
   logic                                    rsp_index_error;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [mapp_pkg::CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [mapp_pkg::CSR_DATA_BITS-1:0]      csr_data = '0;

   // Shadow of the engine: configuration and plane contents as predicted.
   mapp_pkg::cfg_type                       shadow_cfg;
   logic signed [mapp_pkg::SAMPLE_BITS-1:0]
      shadow_plane [0:mapp_pkg::MAX_DIM*mapp_pkg::MAX_DIM-1];
   // Pixels that the stimulus has already written, tracked at generation time.
   bit pixel_written [0:mapp_pkg::MAX_DIM*mapp_pkg::MAX_DIM-1];

   pool_request_type pending_requests [$];
   pool_result_type  expected_results [$];
   pool_request_type request_on_wire;

   int  requests_issued   = 0;
   int  requests_accepted = 0;
   int  responses_seen    = 0;
   int  error_count       = 0;
   int  cycle_count       = 0;
   int  send_gap          = 0;
   int  stall_left        = 0;
   int  hold_left         = 0;
   bit  long_hold_done    = 1'b0;
   bit  sender_calm       = 1'b0;
   bit  receiver_calm     = 1'b0;

   max_avg_pooling_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_index_error  (rsp_index_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int draw_idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // True when the configuration allows any query to be answered.
   function automatic bit config_usable();
      int h, w, win;
      h   = shadow_cfg.image_height;
      w   = shadow_cfg.image_width;
      win = shadow_cfg.window_size;
      if (h == 0 || h > mapp_pkg::MAX_DIM || w == 0 || w > mapp_pkg::MAX_DIM) return 0;
      if (win == 0 || win > mapp_pkg::MAX_WINDOW || shadow_cfg.stride == 0) return 0;
      return (win <= h && win <= w);
   endfunction

   function automatic int pooled_extent(input int size);
      int win, s;
      win = shadow_cfg.window_size;
      s   = shadow_cfg.stride;
      return (size - win + s - 1) / s + 1;
   endfunction

   // Clipped window of a pooled position; returns 0 when the query is an error.
   function automatic bit query_window(input int ph, input int pw,
                                       output int r0, output int r1,
                                       output int c0, output int c1);
      int h, w, win, s;
      h   = shadow_cfg.image_height;
      w   = shadow_cfg.image_width;
      win = shadow_cfg.window_size;
      s   = shadow_cfg.stride;
      r0 = 0; r1 = 0; c0 = 0; c1 = 0;
      if (!config_usable()) return 0;
      if (ph >= pooled_extent(h) || pw >= pooled_extent(w)) return 0;
      r0 = ph * s;
      c0 = pw * s;
      r1 = (r0 + win > h) ? h : r0 + win;
      c1 = (c0 + win > w) ? w : c0 + win;
      return 1;
   endfunction

   function automatic pool_result_type predict_pooling(input int ph, input int pw);
      pool_result_type res;
      int r0, r1, c0, c1;
      int acc, count, v;
      res.pooled_value = '0;
      res.index_error  = 1'b1;
      if (query_window(ph, pw, r0, r1, c0, c1)) begin
         acc   = (shadow_cfg.pool_mode == mapp_pkg::MODE_MAX) ?
                 -(1 << (mapp_pkg::SAMPLE_BITS - 1)) : 0;
         count = 0;
         // An empty window leaves the loops untouched and count at zero.
         for (int r = r0; r < r1; r++) begin
            for (int c = c0; c < c1; c++) begin
               v = shadow_plane[r * mapp_pkg::MAX_DIM + c];
               if (shadow_cfg.pool_mode == mapp_pkg::MODE_MAX) begin
                  if (v > acc) acc = v;
               end else begin
                  acc += v;
               end
               count++;
            end
         end
         if (shadow_cfg.pool_mode == mapp_pkg::MODE_AVG && count != 0) acc = acc / count;
         res.pooled_value = acc[mapp_pkg::SAMPLE_BITS-1:0];
         res.index_error  = 1'b0;
      end
      return res;
   endfunction

   function automatic bit inside_plane(input int row, input int col);
      return (row < shadow_cfg.image_height && col < shadow_cfg.image_width);
   endfunction

   task automatic push_write(input int row, input int col, input int value);
      pool_request_type item;
      item.kind   = mapp_pkg::REQ_WRITE;
      item.row    = mapp_pkg::DIM_BITS'(row);
      item.col    = mapp_pkg::DIM_BITS'(col);
      item.sample = mapp_pkg::SAMPLE_BITS'(value);
      pending_requests.insert(pending_requests.size(), item);
      requests_issued++;
      if (inside_plane(row, col)) pixel_written[row * mapp_pkg::MAX_DIM + col] = 1'b1;
   endtask

   // A query is preceded by writes of every pixel of its window not yet written.
   task automatic push_query(input int ph, input int pw);
      pool_request_type item;
      int r0, r1, c0, c1;
      if (query_window(ph, pw, r0, r1, c0, c1)) begin
         for (int r = r0; r < r1; r++) begin
            for (int c = c0; c < c1; c++) begin
               if (!pixel_written[r * mapp_pkg::MAX_DIM + c]) push_write(r, c, $urandom());
            end
         end
      end
      item.kind   = mapp_pkg::REQ_QUERY;
      item.row    = mapp_pkg::DIM_BITS'(ph);
      item.col    = mapp_pkg::DIM_BITS'(pw);
      item.sample = mapp_pkg::SAMPLE_BITS'($urandom());
      pending_requests.insert(pending_requests.size(), item);
      requests_issued++;
   endtask

   task automatic write_csr(input logic [mapp_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [mapp_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mapp_pkg::CSR_IMAGE_HEIGHT: shadow_cfg.image_height = value;
         mapp_pkg::CSR_IMAGE_WIDTH:  shadow_cfg.image_width  = value;
         mapp_pkg::CSR_WINDOW_SIZE:  shadow_cfg.window_size  = value[mapp_pkg::WIN_BITS-1:0];
         mapp_pkg::CSR_STRIDE:       shadow_cfg.stride       = value;
         mapp_pkg::CSR_POOL_MODE:    shadow_cfg.pool_mode    = value[0];
         default: ;
      endcase
   endtask

   task automatic program_engine(input int h, input int w, input int win,
                                 input int s, input int mode);
      write_csr(mapp_pkg::CSR_IMAGE_HEIGHT, mapp_pkg::CSR_DATA_BITS'(h));
      write_csr(mapp_pkg::CSR_IMAGE_WIDTH, mapp_pkg::CSR_DATA_BITS'(w));
      write_csr(mapp_pkg::CSR_WINDOW_SIZE, mapp_pkg::CSR_DATA_BITS'(win));
      write_csr(mapp_pkg::CSR_STRIDE, mapp_pkg::CSR_DATA_BITS'(s));
      write_csr(mapp_pkg::CSR_POOL_MODE, mapp_pkg::CSR_DATA_BITS'(mode));
   endtask

   // Waits until every queued request has been taken and every response
   // has arrived, then lets a write still in flight settle.
   task automatic wait_until_drained();
      @(negedge clock);
      while (requests_accepted != requests_issued || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_items(input int quota);
      int start, pick, h, w;
      start = requests_issued;
      h = (shadow_cfg.image_height == 0 || shadow_cfg.image_height > mapp_pkg::MAX_DIM) ?
          mapp_pkg::MAX_DIM : shadow_cfg.image_height;
      w = (shadow_cfg.image_width == 0 || shadow_cfg.image_width > mapp_pkg::MAX_DIM) ?
          mapp_pkg::MAX_DIM : shadow_cfg.image_width;
      while (requests_issued - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && config_usable())
            push_query($urandom_range(0, pooled_extent(shadow_cfg.image_height) - 1),
                       $urandom_range(0, pooled_extent(shadow_cfg.image_width) - 1));
         else if (pick < 60)
            push_query($urandom_range(0, mapp_pkg::MAX_DIM - 1),
                       $urandom_range(0, mapp_pkg::MAX_DIM - 1));
         else if (pick < 90)
            push_write($urandom_range(0, h - 1), $urandom_range(0, w - 1), $urandom());
         else
            push_write($urandom_range(0, mapp_pkg::MAX_DIM - 1),
                       $urandom_range(0, mapp_pkg::MAX_DIM - 1), $urandom());
      end
      wait_until_drained();
   endtask

   task automatic run_phase(input int h, input int w, input int win, input int s,
                            input int mode, input int quota);
      program_engine(h, w, win, s, mode);
      run_random_items(quota);
   endtask

   // Request driver: each accepted transfer updates the shadow plane or
   // queues the predicted response.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (request_on_wire.kind == mapp_pkg::REQ_WRITE) begin
               if (inside_plane(request_on_wire.row, request_on_wire.col))
                  shadow_plane[request_on_wire.row * mapp_pkg::MAX_DIM +
                               request_on_wire.col] = request_on_wire.sample;
            end else begin
               expected_results.insert(expected_results.size(),
                                       predict_pooling(request_on_wire.row,
                                                       request_on_wire.col));
            end
            requests_accepted++;
         end
         if ($urandom_range(0, 199) == 0) sender_calm = !sender_calm;
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               request_on_wire = pending_requests.pop_front();
               req_valid     <= 1'b1;
               req_type      <= request_on_wire.kind;
               req_row_index <= request_on_wire.row;
               req_col_index <= request_on_wire.col;
               req_sample    <= request_on_wire.sample;
               send_gap = sender_calm ? 0 : draw_idle_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no query waiting: value %0d error %0b",
                        $time, rsp_pooled_value, rsp_index_error);
               error_count++;
            end else begin
               pool_result_type want;
               want = expected_results.pop_front();
               if (rsp_pooled_value !== want.pooled_value) begin
                  $display("%0t: pooled_value expected %0d got %0d", $time,
                           want.pooled_value, rsp_pooled_value);
                  error_count++;
               end
               if (rsp_index_error !== want.index_error) begin
                  $display("%0t: index_error expected %0b got %0b", $time,
                           want.index_error, rsp_index_error);
                  error_count++;
               end
            end
            responses_seen++;
         end
         if ($urandom_range(0, 199) == 0) receiver_calm = !receiver_calm;
         // One long hold-off lets the engine fill up and stall its input.
         if (!long_hold_done && responses_seen == 150) begin
            long_hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!receiver_calm && $urandom_range(0, 99) < 25) stall_left = draw_idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int h, w, win, s, side;
      shadow_cfg.image_height = 8;
      shadow_cfg.image_width  = 8;
      shadow_cfg.window_size  = 2;
      shadow_cfg.stride       = 2;
      shadow_cfg.pool_mode    = mapp_pkg::MODE_MAX;
      for (int i = 0; i < mapp_pkg::MAX_DIM * mapp_pkg::MAX_DIM; i++) begin
         shadow_plane[i]  = '0;
         pixel_written[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration: sample extremes, dropped
      // writes outside the plane and queries outside the pooled grid.
      push_write(0, 0, 32767);
      push_write(0, 1, -32768);
      push_write(1, 0, -1);
      push_write(1, 1, 0);
      push_query(0, 0);
      push_write(63, 63, 16'h5a5a);
      push_write(8, 3, 1234);
      push_write(3, 8, -1234);
      push_write(2, 2, -32768);
      push_write(2, 3, -32768);
      push_write(3, 2, -32768);
      push_write(3, 3, -32767);
      push_query(1, 1);
      push_query(3, 3);
      push_query(4, 0);
      push_query(0, 4);
      push_query(63, 63);
      wait_until_drained();

      // Average mode: truncation toward zero on negative sums.
      program_engine(8, 8, 2, 2, mapp_pkg::MODE_AVG);
      push_query(0, 0);
      push_query(1, 1);
      push_write(7, 7, 32767);
      push_write(6, 6, -3);
      push_query(3, 3);
      wait_until_drained();

      // Largest plane and window; stride 64 leaves the second grid position empty.
      run_phase(64, 64, 8, 64, mapp_pkg::MODE_MAX, 12);
      run_phase(64, 64, 8, 64, mapp_pkg::MODE_AVG, 8);
      run_phase(1, 1, 1, 1, mapp_pkg::MODE_MAX, 10);
      run_phase(1, 1, 1, 127, mapp_pkg::MODE_AVG, 10);
      run_phase(5, 7, 1, 8, mapp_pkg::MODE_MAX, 20);
      run_phase(5, 7, 3, 127, mapp_pkg::MODE_AVG, 20);
      // Invalid settings and a window larger than the plane: all queries fail.
      run_phase(0, 8, 2, 2, mapp_pkg::MODE_MAX, 15);
      run_phase(127, 8, 2, 2, mapp_pkg::MODE_AVG, 15);
      run_phase(8, 0, 2, 2, mapp_pkg::MODE_MAX, 15);
      run_phase(8, 100, 2, 2, mapp_pkg::MODE_MAX, 15);
      run_phase(8, 8, 0, 2, mapp_pkg::MODE_MAX, 15);
      run_phase(8, 8, 15, 2, mapp_pkg::MODE_AVG, 15);
      run_phase(8, 8, 2, 0, mapp_pkg::MODE_MAX, 15);
      run_phase(3, 8, 4, 1, mapp_pkg::MODE_MAX, 15);
      run_phase(8, 2, 3, 1, mapp_pkg::MODE_AVG, 15);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, mapp_pkg::MAX_DIM)
                                         : $urandom_range(1, 16);
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, mapp_pkg::MAX_DIM)
                                         : $urandom_range(1, 16);
         side = (h < w) ? h : w;
         if (side > mapp_pkg::MAX_WINDOW) side = mapp_pkg::MAX_WINDOW;
         win = ($urandom_range(0, 99) < 85) ? $urandom_range(1, side)
                                             : $urandom_range(1, mapp_pkg::MAX_WINDOW);
         s = ($urandom_range(0, 99) < 80) ? $urandom_range(1, win + 2)
                                           : $urandom_range(1, 127);
         run_phase(h, w, win, s, $urandom_range(0, 1), 100);
      end

      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
